// File: sv/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants and types of the RPC response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

	localparam int HEADER_LEN      = 20;
	localparam int HDR_POS_W       = $clog2(HEADER_LEN);
	localparam int OFS_REQUEST_ID  = 5;
	localparam int OFS_STATUS      = 10;
	localparam int OFS_CLASS_LEN   = 12;
	localparam int OFS_HDR_LEN     = 14;
	localparam int OFS_CONTENT_LEN = 16;
	localparam int BODY_W          = 33;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic EV_HEADER    = 1'b0;
	localparam logic EV_FRAME_END = 1'b1;

	typedef struct packed {
		logic               event_res;
		logic signed [31:0] request_id;
		logic [15:0]        status;
		logic [15:0]        class_len;
		logic [15:0]        hdr_len;
		logic [31:0]        content_len;
		logic               success;
		logic               last;
	} rrd_result_t;

	typedef struct packed {
		logic        push_first;
		logic        push_second;
		rrd_result_t res_first;
		rrd_result_t res_second;
	} rrd_push_t;

endpackage

`default_nettype wire

// File: sv/rrd_in_if.sv
// ----------------------------------------------------------------------------
// rrd_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_last;

	modport source (output valid, output data_byte, output chunk_last, input ready);
	modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

`default_nettype wire

// File: sv/rrd_out_if.sv
// ----------------------------------------------------------------------------
// rrd_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrd_out_if;
	logic               valid;
	logic               ready;
	logic               event_res;
	logic signed [31:0] request_id;
	logic [15:0]        status;
	logic [15:0]        class_len;
	logic [15:0]        hdr_len;
	logic [31:0]        content_len;
	logic               success;
	logic               last;

	modport source (output valid, output event_res, output request_id, output status,
		output class_len, output hdr_len, output content_len, output success,
		output last, input ready);
	modport sink   (input valid, input event_res, input request_id, input status,
		input class_len, input hdr_len, input content_len, input success,
		input last, output ready);
endinterface

`default_nettype wire

// File: sv/rrd_cfg_if.sv
// ----------------------------------------------------------------------------
// rrd_cfg_if
// Configuration write channel carrying the success status code.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] success_status;

	modport source (output valid, output success_status, input ready);
	modport sink   (input valid, input success_status, output ready);
endinterface

`default_nettype wire

// File: sv/rrd_parser.sv
// ----------------------------------------------------------------------------
// rrd_parser
// Header gathering, field decode, body countdown and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_success_status,
	output rrd_pkg::rrd_push_t     push
);
	import rrd_pkg::*;

	logic [7:0]           shift_q [HEADER_LEN-1];
	logic [HDR_POS_W-1:0] pos_q;
	logic [BODY_W-1:0]    body_q;
	logic [31:0]          frame_id_q;
	logic [15:0]          frame_status_q;
	logic [15:0]          succ_q;

	logic [7:0]        hb [HEADER_LEN];
	logic [31:0]       new_id;
	logic [15:0]       new_status;
	logic [15:0]       new_cls;
	logic [15:0]       new_hdr;
	logic [31:0]       new_cont;
	logic [BODY_W-1:0] new_body;
	logic [BODY_W-1:0] body_dec;
	logic              in_body;
	logic              hdr_done;

	always_comb begin
		for (int i = 0; i < HEADER_LEN - 1; i++) begin
			hb[i] = shift_q[i];
		end
		hb[HEADER_LEN-1] = data_byte;
	end

	assign new_id     = {hb[OFS_REQUEST_ID], hb[OFS_REQUEST_ID+1],
		hb[OFS_REQUEST_ID+2], hb[OFS_REQUEST_ID+3]};
	assign new_status = {hb[OFS_STATUS], hb[OFS_STATUS+1]};
	assign new_cls    = {hb[OFS_CLASS_LEN], hb[OFS_CLASS_LEN+1]};
	assign new_hdr    = {hb[OFS_HDR_LEN], hb[OFS_HDR_LEN+1]};
	assign new_cont   = {hb[OFS_CONTENT_LEN], hb[OFS_CONTENT_LEN+1],
		hb[OFS_CONTENT_LEN+2], hb[OFS_CONTENT_LEN+3]};
	assign new_body   = {{(BODY_W-16){1'b0}}, new_cls} + {{(BODY_W-16){1'b0}}, new_hdr}
		+ {{(BODY_W-32){1'b0}}, new_cont};
	assign body_dec   = body_q - {{(BODY_W-1){1'b0}}, 1'b1};
	assign in_body    = (body_q != '0);
	assign hdr_done   = (pos_q == HDR_POS_W'(HEADER_LEN - 1));

	always_comb begin
		push = '0;
		if (fire) begin
			if (in_body) begin
				if (body_dec == '0) begin
					push.push_first             = 1'b1;
					push.res_first.event_res    = EV_FRAME_END;
					push.res_first.request_id   = frame_id_q;
					push.res_first.status       = frame_status_q;
					push.res_first.success      = (frame_status_q == succ_q);
					push.res_first.last         = 1'b1;
				end
			end else if (hdr_done) begin
				push.push_first               = 1'b1;
				push.res_first.event_res      = EV_HEADER;
				push.res_first.request_id     = new_id;
				push.res_first.status         = new_status;
				push.res_first.class_len      = new_cls;
				push.res_first.hdr_len        = new_hdr;
				push.res_first.content_len    = new_cont;
				push.res_first.success        = (new_status == succ_q);
				push.res_first.last           = (new_body != '0);
				if (new_body == '0) begin
					push.push_second            = 1'b1;
					push.res_second.event_res   = EV_FRAME_END;
					push.res_second.request_id  = new_id;
					push.res_second.status      = new_status;
					push.res_second.success     = (new_status == succ_q);
					push.res_second.last        = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !in_body) begin
			for (int i = 0; i < HEADER_LEN - 2; i++) begin
				shift_q[i] <= shift_q[i+1];
			end
			shift_q[HEADER_LEN-2] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			body_q         <= '0;
			frame_id_q     <= '1;
			frame_status_q <= '1;
			succ_q         <= '0;
		end else begin
			if (cfg_we) begin
				succ_q <= cfg_success_status;
			end
			if (fire) begin
				if (in_body) begin
					body_q <= body_dec;
				end else if (hdr_done) begin
					pos_q          <= '0;
					body_q         <= new_body;
					frame_id_q     <= new_id;
					frame_status_q <= new_status;
				end else begin
					pos_q <= pos_q + HDR_POS_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/rrd_out_queue.sv
// ----------------------------------------------------------------------------
// rrd_out_queue
// Small result queue: up to two results in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_out_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rrd_pkg::rrd_push_t   push,
	output logic                      room,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rrd_pkg::rrd_result_t      out_res
);
	import rrd_pkg::*;

	rrd_result_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic [QUEUE_PTR_W-1:0] wr_next;
	logic                   pop;
	logic [QUEUE_CNT_W-1:0] n_push;

	assign wr_next   = wr_q + QUEUE_PTR_W'(1);
	assign out_valid = (cnt_q != '0);
	assign out_res   = entry_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
	assign n_push    = QUEUE_CNT_W'(push.push_first) + QUEUE_CNT_W'(push.push_second);

	always_ff @(posedge clk) begin
		if (push.push_first) begin
			entry_q[wr_q] <= push.res_first;
		end
		if (push.push_second) begin
			entry_q[wr_next] <= push.res_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QUEUE_PTR_W'(n_push);
			cnt_q <= cnt_q + n_push - QUEUE_CNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/rpc_response_deframer_top.sv
// ----------------------------------------------------------------------------
// rpc_response_deframer_top
// Deframes a fixed-header RPC response byte stream into header and frame-end
// results.
//
// in_ch carries one byte per request; chunk_last is carried but not used.
// Each header of HEADER_LEN bytes yields a header result; the body that
// follows is counted down and dropped, and its last byte yields a frame-end
// result. A header announcing an empty body yields both results at once.
// cfg_ch writes the success status code; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// Throughput: one byte per cycle while the queue has room. Each result is
// written into the output queue when the byte that causes it is taken; a
// second result of the same byte is written alongside it. Results wait in a
// four-entry queue; in_ch stalls only while fewer than two entries are free.
// Reset clears the header position, body count and queue; request id and
// status of the last frame reset to all ones, the success code to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_response_deframer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	rrd_in_if.sink    in_ch,
	rrd_out_if.source out_ch,
	rrd_cfg_if.sink   cfg_ch
);
	import rrd_pkg::*;

	rrd_push_t   push;
	rrd_result_t res;
	logic        room;
	logic        fire;

	assign in_ch.ready  = room;
	assign fire         = in_ch.valid && room;
	assign cfg_ch.ready = 1'b1;

	rrd_parser u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (fire),
		.data_byte          (in_ch.data_byte),
		.cfg_we             (cfg_ch.valid),
		.cfg_success_status (cfg_ch.success_status),
		.push               (push)
	);

	rrd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	assign out_ch.event_res   = res.event_res;
	assign out_ch.request_id  = res.request_id;
	assign out_ch.status      = res.status;
	assign out_ch.class_len   = res.class_len;
	assign out_ch.hdr_len     = res.hdr_len;
	assign out_ch.content_len = res.content_len;
	assign out_ch.success     = res.success;
	assign out_ch.last        = res.last;

endmodule

`default_nettype wire

// File: sv/rrd_checker.sv
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the deframer result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_event_res,
	input wire logic        out_last,
	input wire logic [15:0] out_class_len,
	input wire logic [15:0] out_hdr_len,
	input wire logic [31:0] out_content_len
);
	import rrd_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_event_res == EV_HEADER && !out_last
		|=> out_valid && out_event_res == EV_FRAME_END)
		else $error("empty-body header not followed by frame end");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_event_res == EV_FRAME_END
		|-> out_last && out_class_len == '0 && out_hdr_len == '0 && out_content_len == '0)
		else $error("malformed frame-end result");

endmodule

bind rpc_response_deframer_top rrd_checker u_rrd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_event_res   (out_ch.event_res),
	.out_last        (out_ch.last),
	.out_class_len   (out_ch.class_len),
	.out_hdr_len     (out_ch.hdr_len),
	.out_content_len (out_ch.content_len)
);

`default_nettype wire

// File: sim/tb_rpc_response_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_rpc_response_deframer_top
// Self-checking bench for the RPC response deframer. It feeds framed response
// byte streams, rebuilds the header and frame-end results alongside the block
// and compares every result field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rpc_response_deframer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rrd_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS     = 40;

	logic clk = 1'b0;
	logic arst_n;

	rrd_in_if  in_ch ();
	rrd_out_if out_ch ();
	rrd_cfg_if cfg_ch ();

	rpc_response_deframer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0]        hdr_buf [HEADER_LEN];
	int                hdr_pos;
	logic [BODY_W-1:0] body_left;
	logic [31:0]       frm_id;
	logic [15:0]       frm_status;
	logic [15:0]       succ_code;
	rrd_result_t       due_results [$];

	int src_idle_pct  = 0;
	int snk_idle_pct  = 0;
	int hold_off_left = 0;
	int mismatches    = 0;
	int bytes_sent    = 0;
	int headers_seen  = 0;
	int ends_seen     = 0;
	int cfg_writes    = 0;

	function automatic rrd_result_t make_result(input logic ev, input logic [15:0] cls,
		input logic [15:0] hl, input logic [31:0] cl, input logic lst);
		rrd_result_t r;
		r.event_res   = ev;
		r.request_id  = frm_id;
		r.status      = frm_status;
		r.class_len   = cls;
		r.hdr_len     = hl;
		r.content_len = cl;
		r.success     = (frm_status == succ_code);
		r.last        = lst;
		return r;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		logic [15:0] cls;
		logic [15:0] hl;
		logic [31:0] cl;
		if (body_left != '0) begin
			body_left = body_left - BODY_W'(1);
			if (body_left == '0)
				due_results.push_back(make_result(EV_FRAME_END, '0, '0, '0, 1'b1));
			return;
		end
		hdr_buf[hdr_pos] = b;
		hdr_pos++;
		if (hdr_pos < HEADER_LEN)
			return;
		hdr_pos    = 0;
		frm_id     = {hdr_buf[OFS_REQUEST_ID], hdr_buf[OFS_REQUEST_ID + 1],
			hdr_buf[OFS_REQUEST_ID + 2], hdr_buf[OFS_REQUEST_ID + 3]};
		frm_status = {hdr_buf[OFS_STATUS], hdr_buf[OFS_STATUS + 1]};
		cls        = {hdr_buf[OFS_CLASS_LEN], hdr_buf[OFS_CLASS_LEN + 1]};
		hl         = {hdr_buf[OFS_HDR_LEN], hdr_buf[OFS_HDR_LEN + 1]};
		cl         = {hdr_buf[OFS_CONTENT_LEN], hdr_buf[OFS_CONTENT_LEN + 1],
			hdr_buf[OFS_CONTENT_LEN + 2], hdr_buf[OFS_CONTENT_LEN + 3]};
		body_left  = BODY_W'(cls) + BODY_W'(hl) + BODY_W'(cl);
		due_results.push_back(make_result(EV_HEADER, cls, hl, cl, body_left != '0));
		if (body_left == '0)
			due_results.push_back(make_result(EV_FRAME_END, '0, '0, '0, 1'b1));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic mark);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.chunk_last <= mark;
		do
			@(posedge clk);
		while (!in_ch.ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [31:0] id, input logic [15:0] st,
		input logic [15:0] cls, input logic [15:0] hl, input logic [31:0] cl,
		input int body_bytes);
		logic [7:0] hdr [HEADER_LEN];
		foreach (hdr[i])
			hdr[i] = 8'($urandom);
		{hdr[OFS_REQUEST_ID], hdr[OFS_REQUEST_ID + 1], hdr[OFS_REQUEST_ID + 2],
			hdr[OFS_REQUEST_ID + 3]} = id;
		{hdr[OFS_STATUS], hdr[OFS_STATUS + 1]} = st;
		{hdr[OFS_CLASS_LEN], hdr[OFS_CLASS_LEN + 1]} = cls;
		{hdr[OFS_HDR_LEN], hdr[OFS_HDR_LEN + 1]} = hl;
		{hdr[OFS_CONTENT_LEN], hdr[OFS_CONTENT_LEN + 1], hdr[OFS_CONTENT_LEN + 2],
			hdr[OFS_CONTENT_LEN + 3]} = cl;
		foreach (hdr[i])
			send_byte(hdr[i], 1'($urandom));
		repeat (body_bytes)
			send_byte(8'($urandom), 1'($urandom));
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_success(input logic [15:0] code);
		wait_idle();
		cfg_ch.valid          <= 1'b1;
		cfg_ch.success_status <= code;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		succ_code = code;
		cfg_writes++;
	endtask

	task automatic send_random_frame();
		int          total;
		int          pick;
		logic [15:0] st;
		logic [15:0] cls;
		logic [15:0] hl;
		logic [31:0] cl;
		pick = $urandom_range(99);
		if (pick < 30)
			total = 0;
		else if (pick < 85)
			total = $urandom_range(8, 1);
		else
			total = $urandom_range(40, 9);
		cls = 16'($urandom_range(total));
		hl  = 16'($urandom_range(total - int'(cls)));
		cl  = 32'(total - int'(cls) - int'(hl));
		case ($urandom_range(3))
			0:       st = succ_code;
			1:       st = 16'h0000;
			2:       st = 16'hFFFF;
			default: st = 16'($urandom);
		endcase
		send_frame($urandom, st, cls, hl, cl, total);
	endtask

	task automatic test_directed_frames();
		// reset success code is zero
		send_frame(32'h8000_0000, 16'h0000, 16'd0, 16'd0, 32'd0, 0);
		send_frame(32'h7FFF_FFFF, 16'hFFFF, 16'd1, 16'd0, 32'd0, 1);
		send_frame(32'hFFFF_FFFF, 16'h0001, 16'd0, 16'd1, 32'd0, 1);
		send_frame(32'h0000_0000, 16'h8000, 16'd0, 16'd0, 32'd2, 2);
		send_frame($urandom, 16'h0000, 16'd1, 16'd1, 32'd1, 3);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n);
		int start;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start        = bytes_sent;
		while (bytes_sent - start < n)
			send_random_frame();
		wait_idle();
	endtask

	task automatic test_backpressure();
		src_idle_pct  = 0;
		snk_idle_pct  = 0;
		wait_idle();
		// hold the output while empty-body frames keep coming
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (6)
			send_frame($urandom, 16'($urandom), 16'd0, 16'd0, 32'd0, 0);
		wait_idle();
	endtask

	task automatic test_oversized_body();
		// body needs bit 32 of the count; it never ends within the run
		send_frame($urandom, succ_code, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 40);
		wait_idle();
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		rrd_result_t want;
		if (due_results.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: unexpected result, expected none, actual event %b id %h",
					$time, out_ch.event_res, out_ch.request_id);
			mismatches++;
			return;
		end
		want = due_results.pop_front();
		check_field("event_res", 32'(want.event_res), 32'(out_ch.event_res));
		check_field("request_id", want.request_id, out_ch.request_id);
		check_field("status", 32'(want.status), 32'(out_ch.status));
		check_field("class_len", 32'(want.class_len), 32'(out_ch.class_len));
		check_field("hdr_len", 32'(want.hdr_len), 32'(out_ch.hdr_len));
		check_field("content_len", want.content_len, out_ch.content_len);
		check_field("success", 32'(want.success), 32'(out_ch.success));
		check_field("last", 32'(want.last), 32'(out_ch.last));
		if (want.event_res == EV_HEADER)
			headers_seen++;
		else
			ends_seen++;
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			check_result();
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, quiet);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n                <= 1'b0;
		in_ch.valid           <= 1'b0;
		in_ch.data_byte       <= 8'h00;
		in_ch.chunk_last      <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.success_status <= 16'h0000;
		hdr_pos    = 0;
		body_left  = '0;
		frm_id     = '1;
		frm_status = '1;
		succ_code  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 19;
		snk_idle_pct = 62;
		test_directed_frames();
		write_success(16'h0000);
		test_random_traffic(19, 62, 260);
		write_success(16'hFFFF);
		test_random_traffic(62, 19, 260);
		test_backpressure();
		write_success(16'($urandom));
		test_random_traffic(0, 0, 260);
		write_success(16'($urandom));
		test_oversized_body();

		$display("summary: %0d bytes sent, %0d header and %0d frame-end results checked",
			bytes_sent, headers_seen, ends_seen);
		$display("summary: %0d code writes; empty and short bodies, long output hold-off,",
			cfg_writes);
		$display("summary: 33-bit body count");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
sv/rrd_pkg.sv
sv/rrd_in_if.sv
sv/rrd_out_if.sv
sv/rrd_cfg_if.sv
sv/rrd_parser.sv
sv/rrd_out_queue.sv
sv/rpc_response_deframer_top.sv
sv/rrd_checker.sv
sim/tb_rpc_response_deframer_top.sv
